@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/gbe_pkg.sv @@
package gbe_pkg;

   localparam int RATE_W     = 32;
   localparam int OFS_W      = 48;
   localparam int GAIN_W     = 24;
   localparam int PROD_W     = RATE_W + GAIN_W;
   localparam int THR_W      = 31;
   localparam int SAMP_W     = 24;
   localparam int PCT_W      = 7;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 3;
   localparam int CODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = 208;
   localparam int AXES       = 3;

   localparam int TIMER_BITS_DEF     = 24;
   localparam int GAIN_FRAC_BITS_DEF = 24;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // Opcodes
   localparam logic [OP_W-1:0] OP_SAMPLE   = 3'd0;
   localparam logic [OP_W-1:0] OP_START    = 3'd1;
   localparam logic [OP_W-1:0] OP_COMPLETE = 3'd2;
   localparam logic [OP_W-1:0] OP_ABORT    = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD     = 3'd4;

   // Calibration status
   localparam logic [STATUS_W-1:0] STATUS_IDLE  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_RUN   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FAIL  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ABORT = 3'd4;

   // Result codes
   localparam logic [CODE_W-1:0] CODE_OK       = 2'd0;
   localparam logic [CODE_W-1:0] CODE_MOVING   = 2'd1;
   localparam logic [CODE_W-1:0] CODE_NOT_RUN  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CALIB      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONTINUOUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN       = 3'd4;

   localparam logic [THR_W-1:0]  THRESHOLD_RST = 31'd196608;
   localparam logic [SAMP_W-1:0] CALIB_RST     = 24'd1500;
   localparam logic [SAMP_W-1:0] HOLDOFF_RST   = 24'd300;
   localparam logic [GAIN_W-1:0] GAIN_RST      = 24'd21082;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORR,
      ST_EVAL,
      ST_MSTART,
      ST_MWAIT,
      ST_ADD,
      ST_PSTART,
      ST_PWAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } unit_ctl_type;

endpackage

@@ rtl/core/gyro_bias_estimator.sv @@
// Gyro bias estimator. Each req transaction carries an opcode in req_tuser and
// three Q16.16 rates in req_tdata: a sample, or a start / complete / abort
// command, or an offset to load. Samples are corrected by the stored Q16.32
// offset; a stationary sample advances the calibration timer during a run
// and, during a run or in continuous mode after the holdoff, moves the
// offset by gain times the corrected rate. Every transaction yields exactly
// one rsp transaction with the corrected rates, the offset, the result code,
// the calibration status, the percentage done and the completion flag. The
// block works on one transaction at a time and drops req_tready while busy.
// Each offset update runs a shift-add multiplier per axis, and the percentage
// is found by a repeated add that gains one percent per cycle. A finished
// result waits in the output register, so the next transaction may be
// accepted before it is taken.
// Configuration writes through csr_ are always accepted; write only while idle.
module gyro_bias_estimator #(
   parameter int TIMER_BITS     = gbe_pkg::TIMER_BITS_DEF,
   parameter int GAIN_FRAC_BITS = gbe_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // csr write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gbe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gbe_pkg::CSR_DATA_W-1:0]      csr_data,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [95:0]                         req_tdata,  // rate_x, rate_y, rate_z
   input  logic [gbe_pkg::OP_W-1:0]            req_tuser,  // op
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // corrected_x, corrected_y, corrected_z, bias_x, bias_y, bias_z,
   // result_code, calib_status, percent_done, done_flag, zero fill
   output logic [gbe_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import gbe_pkg::*;

   localparam int CW = (TIMER_BITS > SAMP_W) ? TIMER_BITS : SAMP_W;
   localparam int SH = GAIN_FRAC_BITS - 16;

   state_type state_ff, state_in;

   // configuration
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [SAMP_W-1:0] calib_ff, calib_in;
   logic [SAMP_W-1:0] holdoff_ff, holdoff_in;
   logic              cont_ff, cont_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   // item and estimator state
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [RATE_W-1:0] rate_ff [AXES];
   logic signed [RATE_W-1:0] rate_in [AXES];
   logic signed [RATE_W-1:0] corr_ff [AXES];
   logic signed [RATE_W-1:0] corr_in [AXES];
   logic signed [OFS_W-1:0]  ofs_ff  [AXES];
   logic signed [OFS_W-1:0]  ofs_in  [AXES];
   logic [1:0]               axis_ff, axis_in;
   logic                     moving_ff, moving_in;
   logic [CODE_W-1:0]        code_ff, code_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     pend_ff, pend_in;
   logic [TIMER_BITS-1:0]    dur_ff, dur_in;
   logic [TIMER_BITS-1:0]    hold_ff, hold_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // sequencer outputs
   unit_ctl_type mul_ctl, pct_ctl;
   logic         accept, out_free, out_load;

   // shared units
   logic                     mul_done, pct_done;
   logic signed [PROD_W-1:0] mul_prod;
   logic [PCT_W-1:0]         pct_value;

   // datapath temporaries
   logic signed [RATE_W-1:0] ofs_hi;
   logic signed [RATE_W:0]   diff;
   logic signed [RATE_W-1:0] corr_sat;
   logic [RATE_W:0]          corr_mag;
   logic [TIMER_BITS-1:0]    dur_tick, hold_tick;
   logic                     act;
   logic signed [PROD_W-1:0] inc;
   logic signed [OFS_W:0]    ofs_sum;
   logic signed [PROD_W:0]   ofs_wide;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   gbe_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mul_ctl),
      .mul_a    (corr_ff[axis_ff]),
      .mul_b    (gain_ff),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   gbe_pct #(.TIMER_BITS(TIMER_BITS)) u_pct (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pct_ctl),
      .pct_count (dur_ff),
      .pct_limit (calib_ff),
      .pct_done  (pct_done),
      .pct_value (pct_value)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == OP_SAMPLE) ? ST_CORR : ST_EVAL;
            end
         end
         ST_CORR: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL:   state_in = act ? ST_MSTART : ST_PSTART;
         ST_MSTART: state_in = ST_MWAIT;
         ST_MWAIT: begin
            if (mul_done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD:    state_in = (axis_ff == 2'd2) ? ST_PSTART : ST_MSTART;
         ST_PSTART: state_in = ST_PWAIT;
         ST_PWAIT: begin
            if (pct_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      mul_ctl.start = (state_ff == ST_MSTART);
      pct_ctl.start = (state_ff == ST_PSTART);
      out_load      = (state_ff == ST_OUT) && out_free;
   end

   // Datapath
   always_comb begin
      // correction of the current axis, saturated to 32 bits
      ofs_hi = ofs_ff[axis_ff][OFS_W-1:16];
      diff   = (RATE_W + 1)'(rate_ff[axis_ff]) - (RATE_W + 1)'(ofs_hi);
      if (diff[RATE_W] != diff[RATE_W-1]) begin
         corr_sat = diff[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
      end else begin
         corr_sat = diff[RATE_W-1:0];
      end
      corr_mag = corr_sat[RATE_W-1] ? (RATE_W + 1)'(0) - (RATE_W + 1)'(corr_sat)
                                    : (RATE_W + 1)'(corr_sat);

      // saturating timers
      dur_tick  = (&dur_ff)  ? dur_ff  : dur_ff + 1'b1;
      hold_tick = (&hold_ff) ? hold_ff : hold_ff + 1'b1;

      // offset update: truncate the product, saturate the sum
      inc      = mul_prod >>> SH;
      ofs_wide = (PROD_W + 1)'(ofs_ff[axis_ff]) + (PROD_W + 1)'(inc);
      if (ofs_wide[PROD_W:OFS_W-1] != {(PROD_W - OFS_W + 2){ofs_wide[PROD_W]}}) begin
         ofs_sum = ofs_wide[PROD_W] ? (OFS_W + 1)'({1'b1, {(OFS_W-1){1'b0}}})
                                    : (OFS_W + 1)'({1'b0, {(OFS_W-1){1'b1}}});
      end else begin
         ofs_sum = ofs_wide[OFS_W:0];
      end

      thr_in     = thr_ff;
      calib_in   = calib_ff;
      holdoff_in = holdoff_ff;
      cont_in    = cont_ff;
      gain_in    = gain_ff;
      op_in      = op_ff;
      rate_in    = rate_ff;
      corr_in    = corr_ff;
      ofs_in     = ofs_ff;
      axis_in    = axis_ff;
      moving_in  = moving_ff;
      code_in    = code_ff;
      status_in  = status_ff;
      pend_in    = pend_ff;
      dur_in     = dur_ff;
      hold_in    = hold_ff;
      act        = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes; only the register's width is kept
      if (csr_valid) begin
         unique case (csr_index)
            REG_THRESHOLD:  thr_in     = csr_data[THR_W-1:0];
            REG_CALIB:      calib_in   = csr_data[SAMP_W-1:0];
            REG_HOLDOFF:    holdoff_in = csr_data[SAMP_W-1:0];
            REG_CONTINUOUS: cont_in    = csr_data[0];
            REG_GAIN:       gain_in    = csr_data[GAIN_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_tuser;
               rate_in[0] = req_tdata[31:0];
               rate_in[1] = req_tdata[63:32];
               rate_in[2] = req_tdata[95:64];
               for (int i = 0; i < AXES; i++) begin
                  corr_in[i] = '0;
               end
               axis_in   = '0;
               moving_in = 1'b0;
               code_in   = CODE_OK;
            end
         end
         ST_CORR: begin
            corr_in[axis_ff] = corr_sat;
            if (corr_mag > (RATE_W + 1)'(thr_ff)) begin
               moving_in = 1'b1;
            end
            axis_in = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 1'b1;
         end
         ST_EVAL: begin
            unique case (op_ff)
               OP_SAMPLE: begin
                  if (moving_ff) begin
                     hold_in = '0;
                     if (status_ff == STATUS_RUN) begin
                        status_in = STATUS_FAIL;
                        code_in   = CODE_MOVING;
                     end
                  end else begin
                     if (status_ff == STATUS_RUN) begin
                        dur_in = dur_tick;
                        if (CW'(dur_tick) >= CW'(calib_ff)) begin
                           status_in = STATUS_DONE;
                           pend_in   = 1'b1;
                        end else begin
                           act = 1'b1;
                        end
                     end
                     if (cont_ff) begin
                        if (CW'(hold_ff) < CW'(holdoff_ff)) begin
                           hold_in = hold_tick;
                        end else begin
                           act = 1'b1;
                        end
                     end
                  end
               end
               OP_START: begin
                  status_in = STATUS_RUN;
                  pend_in   = 1'b0;
                  dur_in    = '0;
               end
               OP_COMPLETE, OP_ABORT: begin
                  if (status_ff != STATUS_RUN) begin
                     code_in = CODE_NOT_RUN;
                  end else if (op_ff == OP_COMPLETE) begin
                     status_in = STATUS_DONE;
                     pend_in   = 1'b1;
                  end else begin
                     status_in = STATUS_ABORT;
                  end
               end
               OP_LOAD: begin
                  for (int i = 0; i < AXES; i++) begin
                     ofs_in[i] = {rate_ff[i], 16'h0000};
                  end
               end
               default: ;
            endcase
            axis_in = '0;
         end
         ST_ADD: begin
            ofs_in[axis_ff] = ofs_sum[OFS_W-1:0];
            axis_in = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 1'b1;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, pend_ff, pct_value, status_ff, code_ff,
                               ofs_ff[2][OFS_W-1:16], ofs_ff[1][OFS_W-1:16],
                               ofs_ff[0][OFS_W-1:16],
                               corr_ff[2], corr_ff[1], corr_ff[0]};
               pend_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THRESHOLD_RST;
         calib_ff     <= CALIB_RST;
         holdoff_ff   <= HOLDOFF_RST;
         cont_ff      <= 1'b1;
         gain_ff      <= GAIN_RST;
         status_ff    <= STATUS_IDLE;
         pend_ff      <= 1'b0;
         dur_ff       <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            ofs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         calib_ff     <= calib_in;
         holdoff_ff   <= holdoff_in;
         cont_ff      <= cont_in;
         gain_ff      <= gain_in;
         status_ff    <= status_in;
         pend_ff      <= pend_in;
         dur_ff       <= dur_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         ofs_ff       <= ofs_in;
      end
      op_ff       <= op_in;
      rate_ff     <= rate_in;
      corr_ff     <= corr_in;
      axis_ff     <= axis_in;
      moving_ff   <= moving_in;
      code_ff     <= code_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

@@ rtl/core/gbe_mul.sv @@
module gbe_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  gbe_pkg::unit_ctl_type              ctl,
   input  logic signed [gbe_pkg::RATE_W-1:0]  mul_a,
   input  logic        [gbe_pkg::GAIN_W-1:0]  mul_b,
   output logic                               mul_done,
   output logic signed [gbe_pkg::PROD_W-1:0]  mul_prod
);
   import gbe_pkg::*;

   localparam int CNT_W = $clog2(GAIN_W);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [RATE_W-1:0] a_ff, a_in;
   logic [GAIN_W-1:0]        b_ff, b_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] addend;

   // Shift-add, multiplier bits taken MSB first.
   always_comb begin
      addend  = b_ff[GAIN_W-1] ? PROD_W'(a_ff) : '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(GAIN_W - 1);
         a_in    = mul_a;
         b_in    = mul_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + addend;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_done = done_ff;
   assign mul_prod = acc_ff;
endmodule

@@ rtl/core/gbe_pct.sv @@
module gbe_pct #(
   parameter int TIMER_BITS = gbe_pkg::TIMER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gbe_pkg::unit_ctl_type         ctl,
   input  logic [TIMER_BITS-1:0]         pct_count,
   input  logic [gbe_pkg::SAMP_W-1:0]    pct_limit,
   output logic                          pct_done,
   output logic [gbe_pkg::PCT_W-1:0]     pct_value
);
   import gbe_pkg::*;

   localparam int PW = (TIMER_BITS + 7 > 32) ? TIMER_BITS + 7 : 32;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [PCT_W-1:0] q_ff, q_in;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [PW-1:0]    target_ff, target_in;
   logic [PW-1:0]    cnt_ext;
   logic [PW:0]      sum;

   // Count up to 100 while (q + 1) * limit still fits under 100 * count.
   always_comb begin
      cnt_ext   = PW'(pct_count);
      sum       = {1'b0, acc_ff} + (PW + 1)'(pct_limit);
      busy_in   = busy_ff;
      done_in   = 1'b0;
      q_in      = q_ff;
      acc_in    = acc_ff;
      target_in = target_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         q_in      = '0;
         acc_in    = '0;
         target_in = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
      end else if (busy_ff) begin
         if (q_ff == PCT_FULL || sum > {1'b0, target_ff}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = sum[PW-1:0];
            q_in   = q_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff      <= q_in;
      acc_ff    <= acc_in;
      target_ff <= target_in;
   end

   assign pct_done  = done_ff;
   assign pct_value = q_ff;
endmodule

@@ rtl/core/gbe_checker.sv @@
`include "assert_macros.svh"

module gbe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [gbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [gbe_pkg::CSR_DATA_W-1:0]     csr_data,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [95:0]                        req_tdata,
   input logic [gbe_pkg::OP_W-1:0]           req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [gbe_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import gbe_pkg::*;

   // one transaction at a time: busy right after an accept
   `ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // a stalled response stays up
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // percentage is clamped
   `ASSERT_IMPLY(a_pct_range, rsp_tvalid, rsp_tdata[203:197] <= PCT_FULL)
   // a running calibration never reports completion
   `ASSERT_IMPLY(a_run_no_done, rsp_tvalid && rsp_tdata[196:194] == STATUS_RUN, !rsp_tdata[204])
endmodule

bind gyro_bias_estimator gbe_checker u_gbe_checker (.*);

@@ test/gyro_bias_estimator_test.sv @@
`timescale 1ns / 1ps

module gyro_bias_estimator_test;
   import gbe_pkg::*;

   localparam longint OFFSET_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint OFFSET_MIN = -OFFSET_MAX - 1;
   localparam longint TIMER_MAX  = (64'sd1 << TIMER_BITS_DEF) - 1;
   localparam int     STALL_LIMIT = 20000;
   localparam int     PHASE_ITEMS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;      // rate_x, rate_y, rate_z
   logic [OP_W-1:0] req_tuser = '0;  // op
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // corrected_x/y/z, bias_x/y/z, result_code, calib_status, percent_done,
   // done_flag, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   gyro_bias_estimator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the estimator's registers and state.
   longint threshold_reg, calib_reg, holdoff_reg, gain_reg;
   bit continuous_reg;
   longint offset_q32[3];
   logic [STATUS_W-1:0] status_now;
   bit done_pending;
   longint duration_cnt, holdoff_cnt;

   logic [RSP_DATA_W-1:0] pending_reports[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   bit calm = 1'b0;

   // Response field layout, lowest bit first.
   int field_lsb[11] = '{0, 32, 64, 96, 128, 160, 192, 194, 197, 204, 205};
   int field_w[11] = '{32, 32, 32, 32, 32, 32, 2, 3, 7, 1, 3};
   string field_name[11] = '{"corrected_x", "corrected_y", "corrected_z", "bias_x", "bias_y",
      "bias_z", "result_code", "calib_status", "percent_done", "done_flag", "fill"};

   typedef struct {
      logic [OP_W-1:0] op;
      logic [31:0] rx, ry, rz;
      bit typed;
      logic [CODE_W-1:0] code;
      logic [STATUS_W-1:0] status;
      bit done;
   } stim_row_type;

   // Directed rows at the reset settings: threshold is 3.0 dps.
   stim_row_type directed[21] = '{
      '{OP_SAMPLE, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_IDLE, 0},
      '{OP_COMPLETE, 32'h0, 32'h0, 32'h0, 1, CODE_NOT_RUN, STATUS_IDLE, 0},
      '{OP_ABORT, 32'h0, 32'h0, 32'h0, 1, CODE_NOT_RUN, STATUS_IDLE, 0},
      '{OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'h1, 1, CODE_OK, STATUS_IDLE, 0},
      '{OP_SAMPLE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 1, CODE_OK, STATUS_IDLE, 0},
      '{OP_LOAD, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_IDLE, 0},
      '{OP_START, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_RUN, 0},
      '{OP_SAMPLE, 32'h00010000, 32'hFFFE0000, 32'h0, 1, CODE_OK, STATUS_RUN, 0},
      '{OP_SAMPLE, 32'h00040000, 32'h0, 32'h0, 1, CODE_MOVING, STATUS_FAIL, 0},
      '{OP_COMPLETE, 32'h0, 32'h0, 32'h0, 1, CODE_NOT_RUN, STATUS_FAIL, 0},
      '{OP_START, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_RUN, 0},
      '{OP_ABORT, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_ABORT, 0},
      '{OP_START, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_RUN, 0},
      '{OP_COMPLETE, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_DONE, 1},
      '{OP_SAMPLE, 32'h0, 32'h0, 32'h0, 1, CODE_OK, STATUS_DONE, 0},
      '{3'd5, 32'h12345678, 32'h0, 32'h0, 1, CODE_OK, STATUS_DONE, 0},
      '{3'd6, 32'h0, 32'hFFFFFFFF, 32'h0, 1, CODE_OK, STATUS_DONE, 0},
      '{3'd7, 32'h0, 32'h0, 32'h80000000, 1, CODE_OK, STATUS_DONE, 0},
      '{OP_SAMPLE, 32'hFFFFFFFF, 32'h1, 32'h0, 0, CODE_OK, STATUS_IDLE, 0},
      '{OP_SAMPLE, 32'h00030000, 32'h0, 32'hFFFD0000, 0, CODE_OK, STATUS_IDLE, 0},
      '{OP_SAMPLE, 32'hFFFD0000, 32'h00030000, 32'h00030000, 0, CODE_OK, STATUS_IDLE, 0}
   };

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint timer_tick(longint c);
      return (c >= TIMER_MAX) ? TIMER_MAX : c + 1;
   endfunction

   // Advance the shadow state by one transaction and build its response.
   function automatic logic [RSP_DATA_W-1:0] estimate_step(logic [OP_W-1:0] op,
                                                          logic [95:0] rates);
      logic [RSP_DATA_W-1:0] rsp;
      longint rate[3];
      longint corr[3];
      longint mag, total, pct;
      logic [CODE_W-1:0] code;
      bit moving, active;
      rsp = '0;
      code = CODE_OK;
      moving = 0;
      active = 0;
      for (int i = 0; i < 3; i++) begin
         rate[i] = longint'($signed(rates[32*i +: 32]));
         corr[i] = 0;
      end
      case (op)
         OP_SAMPLE: begin
            for (int i = 0; i < 3; i++) begin
               corr[i] = clamp32(rate[i] - (offset_q32[i] >>> 16));
               mag = (corr[i] < 0) ? -corr[i] : corr[i];
               if (mag > threshold_reg) moving = 1;
            end
            if (moving) begin
               holdoff_cnt = 0;
               if (status_now == STATUS_RUN) begin
                  status_now = STATUS_FAIL;
                  code = CODE_MOVING;
               end
            end else begin
               if (status_now == STATUS_RUN) begin
                  duration_cnt = timer_tick(duration_cnt);
                  if (duration_cnt >= calib_reg) begin
                     status_now = STATUS_DONE;
                     done_pending = 1;
                  end else begin
                     active = 1;
                  end
               end
               if (continuous_reg) begin
                  if (holdoff_cnt < holdoff_reg) holdoff_cnt = timer_tick(holdoff_cnt);
                  else active = 1;
               end
               // Move each offset by gain times the corrected rate, floored.
               if (active) begin
                  for (int i = 0; i < 3; i++) begin
                     total = offset_q32[i] + ((corr[i] * gain_reg) >>> (GAIN_FRAC_BITS_DEF - 16));
                     if (total > OFFSET_MAX) total = OFFSET_MAX;
                     if (total < OFFSET_MIN) total = OFFSET_MIN;
                     offset_q32[i] = total;
                  end
               end
            end
         end
         OP_START: begin
            status_now = STATUS_RUN;
            done_pending = 0;
            duration_cnt = 0;
         end
         OP_COMPLETE, OP_ABORT: begin
            if (status_now != STATUS_RUN) begin
               code = CODE_NOT_RUN;
            end else if (op == OP_COMPLETE) begin
               status_now = STATUS_DONE;
               done_pending = 1;
            end else begin
               status_now = STATUS_ABORT;
            end
         end
         OP_LOAD: begin
            for (int i = 0; i < 3; i++) offset_q32[i] = rate[i] * 65536;
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
         rsp[32*i +: 32] = corr[i][31:0];
         rsp[96 + 32*i +: 32] = 32'(offset_q32[i] >>> 16);
      end
      if (calib_reg == 0) begin
         pct = 100;
      end else begin
         pct = (100 * duration_cnt) / calib_reg;
         if (pct > 100) pct = 100;
      end
      rsp[193:192] = code;
      rsp[196:194] = status_now;
      rsp[203:197] = pct[6:0];
      rsp[204] = done_pending;
      done_pending = 0;
      return rsp;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_THRESHOLD: threshold_reg = value[30:0];
         REG_CALIB: calib_reg = value[23:0];
         REG_HOLDOFF: holdoff_reg = value[23:0];
         REG_CONTINUOUS: continuous_reg = value[0];
         REG_GAIN: gain_reg = value[23:0];
         default: ;
      endcase
   endtask

   // Hold off until every expected response is back, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] thr, logic [31:0] calib, logic [31:0] holdoff,
                            logic [31:0] cont, logic [31:0] gain);
      drain();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_CALIB, calib);
      write_reg(REG_HOLDOFF, holdoff);
      write_reg(REG_CONTINUOUS, cont);
      write_reg(REG_GAIN, gain);
      csr_valid <= 1'b0;
   endtask

   // Send one transaction; returns its expected response for the caller to queue.
   task automatic send_item(logic [OP_W-1:0] op, logic [95:0] rates, output logic [RSP_DATA_W-1:0] rsp);
      if (!calm && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 32);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= rates;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rsp = estimate_step(op, rates);
   endtask

   function automatic logic [31:0] near_offset(int axis, longint spread);
      longint v;
      v = (offset_q32[axis] >>> 16) + longint'($urandom_range(0, 32'(spread)))
          * (($urandom_range(1) != 0) ? 1 : -1);
      return 32'(clamp32(v));
   endfunction

   task automatic random_phase(int count);
      logic [RSP_DATA_W-1:0] rsp;
      logic [OP_W-1:0] op;
      logic [95:0] rates;
      longint spread;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2 && $urandom_range(1) != 0) drain();
         pick = $urandom_range(99);
         if (pick < 8) op = OP_START;
         else if (pick < 13) op = OP_COMPLETE;
         else if (pick < 18) op = OP_ABORT;
         else if (pick < 22) op = OP_LOAD;
         else if (pick < 25) op = 3'($urandom_range(5, 7));
         else op = OP_SAMPLE;
         rates = {$urandom, $urandom, $urandom};
         pick = $urandom_range(9);
         if (op == OP_SAMPLE && pick < 8) begin
            // Mostly stationary samples around the current offset.
            spread = (threshold_reg > (64'sd1 << 22)) ? (64'sd1 << 22) : threshold_reg;
            if (pick >= 6) spread = 2 * spread + 1;
            for (int i = 0; i < 3; i++) rates[32*i +: 32] = near_offset(i, spread);
         end else if (op == OP_LOAD && pick < 7) begin
            for (int i = 0; i < 3; i++)
               rates[32*i +: 32] = 32'($signed(18'($urandom)));
         end
         send_item(op, rates, rsp);
         pending_reports.push_back(rsp);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 32);
   end

   // Compare each response field by field against the oldest expectation.
   always @(posedge clock) begin
      logic [RSP_DATA_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_reports.pop_front();
            for (int f = 0; f < 11; f++) begin
               if (((want ^ rsp_tdata) >> field_lsb[f]) & ((208'd1 << field_w[f]) - 1)) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%s: expected %h, got %h", field_name[f],
                              (want >> field_lsb[f]) & ((208'd1 << field_w[f]) - 1),
                              (rsp_tdata >> field_lsb[f]) & ((208'd1 << field_w[f]) - 1));
               end
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [RSP_DATA_W-1:0] rsp;
      threshold_reg = THRESHOLD_RST;
      calib_reg = CALIB_RST;
      holdoff_reg = HOLDOFF_RST;
      continuous_reg = 1;
      gain_reg = GAIN_RST;
      for (int i = 0; i < 3; i++) offset_q32[i] = 0;
      status_now = STATUS_IDLE;
      done_pending = 0;
      duration_cnt = 0;
      holdoff_cnt = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         send_item(directed[k].op, {directed[k].rz, directed[k].ry, directed[k].rx}, rsp);
         if (directed[k].typed) begin
            rsp[193:192] = directed[k].code;
            rsp[196:194] = directed[k].status;
            rsp[204] = directed[k].done;
         end
         pending_reports.push_back(rsp);
      end

      configure(32'd196608, 32'd20, 32'd5, 32'd1, 32'd21082);
      random_phase(PHASE_ITEMS);
      configure(32'd0, 32'd1, 32'd0, 32'd1, 32'hFFFFFF);
      random_phase(PHASE_ITEMS);
      configure(32'hFFFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'd0, 32'd0);
      random_phase(PHASE_ITEMS);
      configure(32'd65536, 32'd0, 32'd2, 32'd1, 32'h800000);
      random_phase(PHASE_ITEMS);
      configure(32'h100000, 32'd37, 32'd0, 32'd0, 32'($urandom_range(0, 24'hFFFFFF)));
      random_phase(PHASE_ITEMS);
      configure(32'($urandom_range(0, 32'h80000)), 32'($urandom_range(1, 60)),
                32'($urandom_range(0, 10)), 32'd1, 32'($urandom_range(0, 24'hFFFFFF)));
      random_phase(PHASE_ITEMS);
      // Last phase with the bench always valid and always ready.
      configure(32'd196608, 32'd100, 32'd10, 32'd1, 32'd21082);
      calm = 1'b1;
      random_phase(PHASE_ITEMS);
      calm = 1'b0;

      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/gbe_pkg.sv
rtl/core/gbe_mul.sv
rtl/core/gbe_pct.sv
rtl/core/gyro_bias_estimator.sv
rtl/core/gbe_checker.sv
test/gyro_bias_estimator_test.sv
